// ===== design/htu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htu_pkg: shared types and constants of the history table update block
// Score and limit widths, the command codes, the divider result bundle and
// the divide-by-ten helper used when aging the table.
// ----------------------------------------------------------------------------
package htu_pkg;

   // field and datapath widths
   localparam int SCORE_W = 16;
   localparam int LIMIT_W = 15;
   localparam int PROD_W  = 32;

   // score_limit after reset
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd3000;

   // reciprocal of ten: n / 10 == (n * 52429) >> 19 for every 16-bit n
   localparam logic [SCORE_W-1:0] AGE_RECIP = 16'd52429;
   localparam int                 AGE_SHIFT = 19;

   // command codes
   typedef enum logic [1:0] {
      CMD_UPDATE = 2'd0,
      CMD_AGE    = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_READ   = 2'd3
   } htu_cmd_type;

   // divider status and result
   typedef struct packed {
      logic               done;
      logic [SCORE_W-1:0] quotient;
   } htu_div_result_type;

   // signed divide by ten, truncating toward zero
   function automatic logic [SCORE_W-1:0] age_div(input logic [SCORE_W-1:0] score);
      logic [SCORE_W-1:0]   mag;
      logic [2*SCORE_W-1:0] prod;
      logic [SCORE_W-1:0]   quo;
      mag  = score[SCORE_W-1] ? (~score + 1'b1) : score;
      prod = {{SCORE_W{1'b0}}, mag} * {{SCORE_W{1'b0}}, AGE_RECIP};
      quo  = SCORE_W'(prod >> AGE_SHIFT);
      return score[SCORE_W-1] ? (~quo + 1'b1) : quo;
   endfunction

endpackage

// ===== design/htu_score_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htu_score_mem: score table storage
// Single write port and single read port, read data registered. A read at the
// address being written returns the old entry.
// ----------------------------------------------------------------------------
module htu_score_mem
   import htu_pkg::*;
#(
   parameter int DEPTH  = 8192,
   parameter int ADDR_W = 13
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [SCORE_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [SCORE_W-1:0] rd_data
);

   logic [SCORE_W-1:0] mem [DEPTH];
   logic [SCORE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/htu_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htu_divider: radix-4 restoring divider
// Divides an unsigned 32-bit product by the 15-bit limit, two quotient bits
// per cycle. Only the low 16 quotient bits are kept, since the score update
// wraps to 16 bits anyway.
// ----------------------------------------------------------------------------
module htu_divider
   import htu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [PROD_W-1:0]   dividend,
   input  logic [LIMIT_W-1:0]  divisor,
   output htu_div_result_type  result
);

   localparam int STEPS = PROD_W / 2;
   localparam int CNT_W = $clog2(STEPS);

   logic               run_ff,  run_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff,  cnt_in;
   logic [LIMIT_W-1:0] rem_ff,  rem_in;
   logic [PROD_W-1:0]  dvd_ff,  dvd_in;
   logic [SCORE_W-1:0] quo_ff,  quo_in;

   logic [LIMIT_W:0]   div_ext;
   logic [LIMIT_W:0]   t1, r1, t2, r2;
   logic               ge1, ge2;

   // two dependent compare-subtract steps
   always_comb begin
      div_ext = {1'b0, divisor};
      t1      = {rem_ff, dvd_ff[PROD_W-1]};
      ge1     = (t1 >= div_ext);
      r1      = ge1 ? (t1 - div_ext) : t1;
      t2      = {r1[LIMIT_W-1:0], dvd_ff[PROD_W-2]};
      ge2     = (t2 >= div_ext);
      r2      = ge2 ? (t2 - div_ext) : t2;
   end

   // iteration control
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         dvd_in = dividend;
         quo_in = '0;
      end else if (run_ff) begin
         rem_in = r2[LIMIT_W-1:0];
         dvd_in = {dvd_ff[PROD_W-3:0], 2'b00};
         quo_in = {quo_ff[SCORE_W-3:0], ge1, ge2};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   assign result.done     = done_ff;
   assign result.quotient = quo_ff;

endmodule

// ===== design/history_table_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// history_table_update: history heuristic score table
// Keeps one signed 16-bit score per side, from-square and to-square, with a
// gravity-style update, table-wide aging by ten, clearing and reads.
// ----------------------------------------------------------------------------
// One command is in flight at a time; busy is high from the beat after start
// until the result strobe. With D = NUM_SIDES*NUM_SQUARES*NUM_SQUARES table
// entries, an update runs the entry read, one multiply, divider load, the
// two-bit-per-cycle divider and write back with the result. Age walks the
// table once with the reads one entry ahead of the write back, and clear
// writes every entry; both are bounded by the one write per cycle of the
// table memory. After reset the table is cleared in one pass over all D
// entries (8192 at the default sizes) with busy high; the csr port is usable
// during that pass. rsp_valid is a one-cycle strobe that cannot be held off,
// and an item with an address outside the table returns zero.
// ----------------------------------------------------------------------------
module history_table_update
   import htu_pkg::*;
#(
   parameter int NUM_SIDES   = 2,
   parameter int NUM_SQUARES = 64
) (
   input  logic                clock,
   input  logic                reset,
   // command beat
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_cmd,
   input  logic                req_side,
   input  logic [5:0]          req_from_square,
   input  logic [5:0]          req_to_square,
   input  logic signed [15:0]  req_bonus,
   // result beat
   output logic                rsp_valid,
   output logic signed [15:0]  rsp_entry_value,
   // register port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam int DEPTH  = NUM_SIDES * NUM_SQUARES * NUM_SQUARES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = ADDR_W + 1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_READ,
      ST_UPD_MUL,
      ST_UPD_START,
      ST_UPD_DIV,
      ST_AGE,
      ST_FIN_READ,
      ST_FIN_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   logic [ADDR_W-1:0]  waddr_ff, waddr_in;
   logic               emit_ff, emit_in;
   logic               ok_ff, ok_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [SCORE_W-1:0] bonus_ff, bonus_in;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic               neg_ff, neg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;

   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic [SCORE_W-1:0] mem_wr_data;
   logic               mem_rd_en;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic [SCORE_W-1:0] mem_rd_data;

   logic               div_start;
   logic [LIMIT_W-1:0] div_divisor;
   htu_div_result_type div_result;

   logic               accept;
   logic               csr_wr;
   logic [31:0]        idx_wide;
   logic               addr_ok;
   logic [SCORE_W-1:0] bonus_mag;
   logic [SCORE_W-1:0] score_mag;
   logic [SCORE_W-1:0] q_signed;
   logic [SCORE_W-1:0] upd_value;

   // register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && !paddr[2];
   assign prdata = paddr[2] ? 32'd0 : {{(32 - LIMIT_W){1'b0}}, limit_ff};
   assign limit_in = csr_wr ? pwdata[LIMIT_W-1:0] : limit_ff;

   // address of the entry and range check
   assign accept   = start && !busy;
   assign idx_wide = (32'(req_side) * 32'(NUM_SQUARES) + 32'(req_from_square))
                     * 32'(NUM_SQUARES) + 32'(req_to_square);
   assign addr_ok  = (32'(req_side) < 32'(NUM_SIDES))
                     && (32'(req_from_square) < 32'(NUM_SQUARES))
                     && (32'(req_to_square) < 32'(NUM_SQUARES));

   // magnitudes for the gravity term
   assign bonus_mag = bonus_ff[SCORE_W-1] ? (~bonus_ff + 1'b1) : bonus_ff;
   assign score_mag = mem_rd_data[SCORE_W-1] ? (~mem_rd_data + 1'b1) : mem_rd_data;

   // signed quotient and new score, wrapped to 16 bits
   assign q_signed  = neg_ff ? (~div_result.quotient + 1'b1) : div_result.quotient;
   assign upd_value = score_ff + bonus_ff - q_signed;

   assign div_start   = (state_ff == ST_UPD_START);
   assign div_divisor = (limit_ff == '0) ? LIMIT_W'(1) : limit_ff;

   // memory port control
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff;
      mem_wr_data = upd_value;
      mem_rd_en   = 1'b0;
      mem_rd_addr = idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cnt_ff[ADDR_W-1:0];
            mem_wr_data = '0;
         end
         ST_UPD_READ, ST_FIN_READ: begin
            mem_rd_en = 1'b1;
         end
         ST_UPD_DIV: begin
            mem_wr_en = div_result.done;
         end
         ST_AGE: begin
            mem_rd_en   = (cnt_ff < CNT_W'(DEPTH));
            mem_rd_addr = cnt_ff[ADDR_W-1:0];
            mem_wr_en   = pend_ff;
            mem_wr_addr = waddr_ff;
            mem_wr_data = age_div(mem_rd_data);
         end
         default: begin
         end
      endcase
   end

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      waddr_in     = waddr_ff;
      emit_in      = emit_ff;
      ok_in        = ok_ff;
      idx_in       = idx_ff;
      bonus_in     = bonus_ff;
      score_in     = score_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
               if (emit_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = '0;
               end
               emit_in = 1'b0;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               ok_in    = addr_ok;
               idx_in   = addr_ok ? idx_wide[ADDR_W-1:0] : '0;
               bonus_in = req_bonus;
               cnt_in   = '0;
               case (htu_cmd_type'(req_cmd))
                  CMD_UPDATE: state_in = addr_ok ? ST_UPD_READ : ST_FIN_READ;
                  CMD_AGE:    state_in = ST_AGE;
                  CMD_CLEAR: begin
                     state_in = ST_CLEAR;
                     emit_in  = 1'b1;
                  end
                  CMD_READ:   state_in = ST_FIN_READ;
                  default:    state_in = ST_FIN_READ;
               endcase
            end
         end
         ST_UPD_READ: begin
            state_in = ST_UPD_MUL;
         end
         ST_UPD_MUL: begin
            score_in = mem_rd_data;
            neg_in   = mem_rd_data[SCORE_W-1];
            prod_in  = {{SCORE_W{1'b0}}, score_mag} * {{SCORE_W{1'b0}}, bonus_mag};
            state_in = ST_UPD_START;
         end
         ST_UPD_START: begin
            state_in = ST_UPD_DIV;
         end
         ST_UPD_DIV: begin
            if (div_result.done) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = upd_value;
               state_in     = ST_IDLE;
            end
         end
         ST_AGE: begin
            // reads run one entry ahead of the write back
            if (cnt_ff < CNT_W'(DEPTH)) begin
               pend_in  = 1'b1;
               waddr_in = cnt_ff[ADDR_W-1:0];
               cnt_in   = cnt_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = ST_FIN_READ;
            end
         end
         ST_FIN_READ: begin
            state_in = ST_FIN_OUT;
         end
         ST_FIN_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = ok_ff ? mem_rd_data : '0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
      end
      waddr_ff     <= waddr_in;
      ok_ff        <= ok_in;
      idx_ff       <= idx_in;
      bonus_ff     <= bonus_in;
      score_ff     <= score_in;
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_value = rsp_value_ff;

   // score table
   htu_score_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // gravity term divider
   htu_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (div_divisor),
      .result   (div_result)
   );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for history_table_update
// Drives command beats through the start/busy handshake and mirrors the score
// table in a local predictor. Each result strobe is checked in order against
// the predicted entry value. Directed corners come first, then random traffic
// under several score_limit settings written over the register port.
// ----------------------------------------------------------------------------
module testbench;
   import htu_pkg::*;

   localparam int TB_SIDES       = 2;
   localparam int TB_SQUARES     = 64;
   localparam int TABLE_DEPTH    = TB_SIDES * TB_SQUARES * TB_SQUARES;
   localparam int AGE_DIVISOR    = 10;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int HOT_ENTRIES    = 6;
   localparam logic [2:0] SCORE_LIMIT_ADDR = 3'd0;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_cmd = CMD_READ;
   logic               req_side = 1'b0;
   logic [5:0]         req_from_square = '0;
   logic [5:0]         req_to_square = '0;
   logic signed [15:0] req_bonus = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_entry_value;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   // predictor state and checking
   logic signed [15:0] score_mirror [TABLE_DEPTH];
   logic [14:0]        limit_mirror = LIMIT_RESET;
   logic signed [15:0] expected_entry_q [$];
   int                 error_count = 0;
   int                 idle_cycles = 0;

   history_table_update dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_side        (req_side),
      .req_from_square (req_from_square),
      .req_to_square   (req_to_square),
      .req_bonus       (req_bonus),
      .rsp_valid       (rsp_valid),
      .rsp_entry_value (rsp_entry_value),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #1 clock = ~clock;

   // apply one command to the mirror and return the addressed entry after it
   function automatic logic signed [15:0] predict_entry(input htu_cmd_type cmd,
         input logic side, input logic [5:0] from_sq, input logic [5:0] to_sq,
         input logic signed [15:0] bonus);
      logic   in_range;
      int     idx;
      longint cur;
      longint mag;
      longint lim;
      longint quo;
      in_range = side < TB_SIDES && from_sq < TB_SQUARES && to_sq < TB_SQUARES;
      idx = in_range ? (int'(side) * TB_SQUARES + from_sq) * TB_SQUARES + to_sq : 0;
      case (cmd)
         CMD_UPDATE: begin
            if (in_range) begin
               cur = longint'(score_mirror[idx]);
               mag = (bonus < 0) ? -longint'(bonus) : longint'(bonus);
               lim = (limit_mirror == 0) ? 1 : longint'(limit_mirror);
               // signed division truncates toward zero
               quo = (cur * mag) / lim;
               score_mirror[idx] = 16'(cur + longint'(bonus) - quo);
            end
         end
         CMD_AGE: begin
            foreach (score_mirror[i])
               score_mirror[i] = 16'(int'(score_mirror[i]) / AGE_DIVISOR);
         end
         CMD_CLEAR: begin
            foreach (score_mirror[i]) score_mirror[i] = '0;
         end
         default: ;
      endcase
      return in_range ? score_mirror[idx] : 16'sd0;
   endfunction

   // bonus mix: extremes, small steps and full-range values
   function automatic logic signed [15:0] random_bonus();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         case ($urandom_range(0, 3))
            0: return -16'sd32768;
            1: return -16'sd32767;
            2: return 16'sd32767;
            default: return 16'sd0;
         endcase
      end else if (pick < 4) begin
         return 16'($signed($urandom_range(0, 600)) - 300);
      end
      return 16'($urandom_range(0, 65535));
   endfunction

   // present one command beat and hold it until accepted
   task automatic send_command(input htu_cmd_type cmd, input logic side,
         input logic [5:0] from_sq, input logic [5:0] to_sq,
         input logic signed [15:0] bonus);
      start           <= 1'b1;
      req_cmd         <= cmd;
      req_side        <= side;
      req_from_square <= from_sq;
      req_to_square   <= to_sq;
      req_bonus       <= bonus;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_entry_q.push_back(predict_entry(cmd, side, from_sq, to_sq, bonus));
   endtask

   // sender gap with start held low
   task automatic sender_pause(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // stop sending and wait for every outstanding result
   task automatic wait_results_done();
      start <= 1'b0;
      do @(posedge clock); while (expected_entry_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // register write: setup cycle, then access cycle until pready
   task automatic write_score_limit(input int unsigned value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= SCORE_LIMIT_ADDR;
      pwdata  <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      limit_mirror = 15'(value);
   endtask

   // corners at the reset limit: table edges, bonus extremes, age and clear
   task automatic test_directed_cases();
      send_command(CMD_READ,   1'b0, 6'd0,  6'd0,  16'sd0);
      send_command(CMD_READ,   1'b1, 6'd63, 6'd63, -16'sd1);
      send_command(CMD_UPDATE, 1'b0, 6'd0,  6'd0,  16'sd32767);
      send_command(CMD_UPDATE, 1'b0, 6'd0,  6'd0,  16'sd32767);
      send_command(CMD_UPDATE, 1'b1, 6'd63, 6'd63, -16'sd32768);
      send_command(CMD_UPDATE, 1'b1, 6'd63, 6'd63, -16'sd32767);
      send_command(CMD_UPDATE, 1'b1, 6'd63, 6'd63, -16'sd32768);
      send_command(CMD_UPDATE, 1'b0, 6'd63, 6'd0,  16'sd0);
      send_command(CMD_UPDATE, 1'b1, 6'd0,  6'd63, 16'sd1);
      send_command(CMD_UPDATE, 1'b1, 6'd0,  6'd63, -16'sd1);
      send_command(CMD_UPDATE, 1'b0, 6'd21, 6'd42, 16'sd12345);
      send_command(CMD_UPDATE, 1'b0, 6'd42, 6'd21, -16'sd12345);
      send_command(CMD_READ,   1'b0, 6'd0,  6'd0,  16'sd32767);
      // aging returns the addressed entry after the divide
      send_command(CMD_AGE,    1'b0, 6'd21, 6'd42, 16'sd0);
      send_command(CMD_READ,   1'b1, 6'd63, 6'd63, 16'sd0);
      send_command(CMD_AGE,    1'b1, 6'd63, 6'd63, -16'sd32768);
      send_command(CMD_READ,   1'b0, 6'd42, 6'd21, 16'sd0);
      // read leaves the entry alone
      send_command(CMD_READ,   1'b0, 6'd42, 6'd21, 16'sd0);
      send_command(CMD_CLEAR,  1'b1, 6'd63, 6'd63, 16'sd0);
      send_command(CMD_READ,   1'b0, 6'd0,  6'd0,  16'sd0);
      send_command(CMD_UPDATE, 1'b0, 6'd42, 6'd21, -16'sd12345);
      send_command(CMD_READ,   1'b0, 6'd42, 6'd21, 16'sd0);
   endtask

   // a limit of zero acts as one
   task automatic test_zero_limit();
      wait_results_done();
      write_score_limit(0);
      send_command(CMD_UPDATE, 1'b1, 6'd17, 6'd9, 16'sd32767);
      send_command(CMD_UPDATE, 1'b1, 6'd17, 6'd9, 16'sd100);
      send_command(CMD_UPDATE, 1'b1, 6'd17, 6'd9, -16'sd32768);
      send_command(CMD_UPDATE, 1'b1, 6'd17, 6'd9, -16'sd1);
      send_command(CMD_UPDATE, 1'b0, 6'd9,  6'd17, 16'sd1);
      send_command(CMD_READ,   1'b1, 6'd17, 6'd9, 16'sd0);
   endtask

   // random beats in bursts, mostly updates on a few hot entries
   task automatic test_random_traffic(input int unsigned limit, input int count);
      int            burst_left;
      int unsigned   pick;
      int unsigned   hot_addr [HOT_ENTRIES];
      logic [12:0]   addr;
      htu_cmd_type   cmd;
      wait_results_done();
      write_score_limit(limit);
      foreach (hot_addr[i]) hot_addr[i] = $urandom_range(0, TABLE_DEPTH - 1);
      burst_left = $urandom_range(1, 30);
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick == 0)
            cmd = CMD_AGE;
         else if (pick == 1)
            cmd = CMD_CLEAR;
         else if (pick < 22)
            cmd = CMD_READ;
         else
            cmd = CMD_UPDATE;
         if ($urandom_range(0, 3) == 0)
            addr = 13'($urandom_range(0, 8191));
         else
            addr = 13'(hot_addr[$urandom_range(0, HOT_ENTRIES - 1)]);
         send_command(cmd, addr[12], addr[11:6], addr[5:0], random_bonus());
         burst_left--;
         if (burst_left == 0) begin
            sender_pause($urandom_range(1, 24));
            burst_left = $urandom_range(1, 30);
         end
      end
   endtask

   // compare each result strobe with the oldest prediction
   always @(posedge clock) begin : check_results
      logic signed [15:0] expected_value;
      if (!reset && rsp_valid) begin
         if (expected_entry_q.size() == 0) begin
            $display("%0t: result with none pending, expected none, actual entry_value %0d",
                     $time, rsp_entry_value);
            error_count++;
         end else begin
            expected_value = expected_entry_q.pop_front();
            if (rsp_entry_value !== expected_value) begin
               $display("%0t: entry_value mismatch, expected %0d, actual %0d",
                        $time, expected_value, rsp_entry_value);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no beat accepted on either side
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, no beat for %0d cycles", $time, idle_cycles);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      foreach (score_mirror[i]) score_mirror[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_traffic(1, 75);
      test_zero_limit();
      test_random_traffic(32767, 75);
      test_random_traffic($urandom_range(2, 32766), 75);
      test_random_traffic($urandom_range(1, 64), 75);
      test_random_traffic(3000, 75);

      wait_results_done();
      repeat (30) @(posedge clock);
      if (expected_entry_q.size() != 0) begin
         $display("%0t: results missing, expected %0d more, actual 0",
                  $time, expected_entry_q.size());
         error_count++;
      end
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== history_table_update.f =====
design/htu_pkg.sv
design/htu_score_mem.sv
design/htu_divider.sv
design/history_table_update.sv
sim/testbench.sv
